/* design/adctpc_pkg.sv */
// Shared types, constants and decode helpers for the ADC two-point calibration block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package adctpc_pkg;

  localparam int unsigned FuseW     = 32;
  localparam int unsigned LowCodeW  = 7;
  localparam int unsigned HighCodeW = 9;
  localparam int unsigned U1LowLsb  = 0;
  localparam int unsigned U1HighLsb = 7;
  localparam int unsigned U2LowLsb  = 16;
  localparam int unsigned U2HighLsb = 23;

  // Signed working width of the rebuilt raw readings, and the step of 4 counts.
  localparam int unsigned PtW       = 14;
  localparam int unsigned StepShift = 2;

  localparam int unsigned SpanW   = 13;
  localparam int unsigned SlopeW  = 17;  // one quotient bit per cell
  localparam int unsigned IcptW   = 11;
  localparam int unsigned OffsetW = 7;
  localparam int unsigned RemSW   = 28;
  localparam int unsigned RemIW   = 22;
  localparam int unsigned CmpW    = SpanW + SlopeW - 1;

  localparam int unsigned LowVMv  = 150;
  localparam int unsigned HighVMv = 850;
  localparam int unsigned DvMv    = HighVMv - LowVMv;

  localparam logic [LowCodeW-1:0]  LowSignOnly  = {1'b1, {(LowCodeW-1){1'b0}}};
  localparam logic [HighCodeW-1:0] HighSignOnly = {1'b1, {(HighCodeW-1){1'b0}}};

  localparam logic [SpanW-1:0] LowNom  [2] = '{SpanW'(278), SpanW'(421)};
  localparam logic [SpanW-1:0] HighNom [2] = '{SpanW'(3265), SpanW'(3406)};

  // Slope numerators: 700 times the per-unit, per-attenuation scale.
  localparam logic [RemSW-1:0] SlopeNum [2][4] = '{
    '{RemSW'(65504 * DvMv), RemSW'(86975 * DvMv),
      RemSW'(120389 * DvMv), RemSW'(224310 * DvMv)},
    '{RemSW'(65467 * DvMv), RemSW'(86861 * DvMv),
      RemSW'(120416 * DvMv), RemSW'(224708 * DvMv)}
  };

  localparam logic [OffsetW-1:0] OffsetTab [2][4] = '{
    '{OffsetW'(0), OffsetW'(1), OffsetW'(27), OffsetW'(54)},
    '{OffsetW'(0), OffsetW'(9), OffsetW'(26), OffsetW'(66)}
  };

  // Division operands and partial quotients handed from cell to cell.
  typedef struct packed {
    logic [SpanW-1:0]   span;
    logic [RemSW-1:0]   rem_s;
    logic [RemIW-1:0]   rem_i;
    logic [SlopeW-1:0]  quo_s;
    logic [IcptW-1:0]   quo_i;
    logic [OffsetW-1:0] offset;
  } div_t;

  // Two's complement decode; the code with only its sign bit set reads as zero.
  function automatic logic signed [LowCodeW-1:0] dec_low(input logic [LowCodeW-1:0] code);
    dec_low = (code == LowSignOnly) ? '0 : signed'(code);
  endfunction

  function automatic logic signed [HighCodeW-1:0] dec_high(
    input logic [HighCodeW-1:0] code
  );
    dec_high = (code == HighSignOnly) ? '0 : signed'(code);
  endfunction

endpackage

/* design/adctpc_if.sv */
// Handshake channel interfaces: configuration write, request and response.
// Depends on adctpc_pkg for field widths.
`timescale 1ns / 1ps

interface adctpc_cfg_if;
  import adctpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [FuseW-1:0] fuse_word;
  modport source (output valid, fuse_word, input ready);
  modport sink   (input valid, fuse_word, output ready);
endinterface

interface adctpc_req_if;
  logic       valid;
  logic       ready;
  logic       adc_unit;
  logic [1:0] attenuation;
  modport source (output valid, adc_unit, attenuation, input ready);
  modport sink   (input valid, adc_unit, attenuation, output ready);
endinterface

interface adctpc_rsp_if;
  import adctpc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SlopeW-1:0]       slope;
  logic signed [IcptW-1:0] intercept;
  modport source (output valid, slope, intercept, input ready);
  modport sink   (input valid, slope, intercept, output ready);
endinterface

/* design/adctpc_front.sv */
// Front stage: picks the unit's fuse fields, rebuilds both raw readings and
// forms span and the two dividends. Depends on adctpc_pkg.
`timescale 1ns / 1ps

module adctpc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic                           adc_unit_i,
  input  logic [1:0]                     attenuation_i,
  input  logic [adctpc_pkg::FuseW-1:0]   fuse_word_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output adctpc_pkg::div_t               data_o
);
  import adctpc_pkg::*;

  logic                  valid_q;
  div_t                  data_q;
  div_t                  data_d;
  logic [LowCodeW-1:0]   low_code;
  logic [HighCodeW-1:0]  high_code;
  logic signed [PtW-1:0] low_pt;
  logic signed [PtW-1:0] high_pt;
  logic [SpanW-1:0]      span;

  always_comb begin
    low_code  = adc_unit_i ? fuse_word_i[U2LowLsb +: LowCodeW]
                           : fuse_word_i[U1LowLsb +: LowCodeW];
    high_code = adc_unit_i ? fuse_word_i[U2HighLsb +: HighCodeW]
                           : fuse_word_i[U1HighLsb +: HighCodeW];
    low_pt  = signed'(PtW'(LowNom[adc_unit_i])) + (PtW'(dec_low(low_code)) <<< StepShift);
    high_pt = signed'(PtW'(HighNom[adc_unit_i])) + (PtW'(dec_high(high_code)) <<< StepShift);
    span    = SpanW'(high_pt - low_pt);

    // Add half the span to both dividends so the quotients come out rounded.
    data_d.span   = span;
    data_d.rem_s  = SlopeNum[adc_unit_i][attenuation_i] + RemSW'(span >> 1);
    data_d.rem_i  = RemIW'(RemIW'(high_pt[SpanW-1:0]) * RemIW'(DvMv)) + RemIW'(span >> 1);
    data_d.quo_s  = '0;
    data_d.quo_i  = '0;
    data_d.offset = OffsetTab[adc_unit_i][attenuation_i];
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/adctpc_cell.sv */
// Division cell: resolves one quotient bit of the slope division, and of the intercept
// division below bit IcptW, and registers the item for the next cell. Depends on adctpc_pkg.
`timescale 1ns / 1ps

module adctpc_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  adctpc_pkg::div_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output adctpc_pkg::div_t data_o
);
  import adctpc_pkg::*;

  logic             valid_q;
  div_t             data_q;
  div_t             data_d;
  logic [CmpW-1:0]  div_sh;
  logic [RemIW-1:0] rem_i_d;
  logic [IcptW-1:0] quo_i_d;

  assign div_sh = CmpW'(data_i.span) << Shift;

  // The intercept quotient stays below 2**IcptW, so higher cells leave it alone.
  if (Shift < IcptW) begin : g_icpt
    always_comb begin
      rem_i_d = data_i.rem_i;
      quo_i_d = data_i.quo_i;
      if (CmpW'(data_i.rem_i) >= div_sh) begin
        rem_i_d        = RemIW'(CmpW'(data_i.rem_i) - div_sh);
        quo_i_d[Shift] = 1'b1;
      end
    end
  end else begin : g_no_icpt
    assign rem_i_d = data_i.rem_i;
    assign quo_i_d = data_i.quo_i;
  end

  always_comb begin
    data_d       = data_i;
    data_d.rem_i = rem_i_d;
    data_d.quo_i = quo_i_d;
    if (CmpW'(data_i.rem_s) >= div_sh) begin
      data_d.rem_s        = RemSW'(CmpW'(data_i.rem_s) - div_sh);
      data_d.quo_s[Shift] = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/adc_two_point_calibration_coeffs.sv */
// Top level: fuse register, front stage, chain of 17 division cells, output register.
// Throughput: one item per cycle unless the output stalls; each cell retires one
// quotient bit of the slope division and, below bit 11, of the intercept division.
// Stalls collapse bubbles, so requests are taken while a finished result waits.
// Reset clears the fuse word to zero and empties every stage.
`timescale 1ns / 1ps

module adc_two_point_calibration_coeffs (
  input  logic                clk_i,
  input  logic                rst_ni,
  adctpc_cfg_if.sink          cfg_i,
  adctpc_req_if.sink          req_i,
  adctpc_rsp_if.source        rsp_o
);
  import adctpc_pkg::*;

  logic [FuseW-1:0]        fuse_q;
  logic                    vld [SlopeW+1];
  logic                    rdy [SlopeW+1];
  div_t                    stage [SlopeW+1];
  logic                    rsp_vld_q;
  logic [SlopeW-1:0]       rsp_slope_q;
  logic signed [IcptW-1:0] rsp_icpt_q;
  logic [IcptW:0]          icpt_sum;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fuse_q <= '0;
    end else if (cfg_i.valid) begin
      fuse_q <= cfg_i.fuse_word;
    end
  end

  adctpc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (req_i.valid),
    .ready_o       (req_i.ready),
    .adc_unit_i    (req_i.adc_unit),
    .attenuation_i (req_i.attenuation),
    .fuse_word_i   (fuse_q),
    .valid_o       (vld[0]),
    .ready_i       (rdy[0]),
    .data_o        (stage[0])
  );

  // Cells run from the top quotient bit down to bit zero.
  for (genvar k = 0; k < SlopeW; k++) begin : g_cell
    adctpc_cell #(
      .Shift (SlopeW - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .data_i  (stage[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .data_o  (stage[k+1])
    );
  end

  assign rdy[SlopeW] = !rsp_vld_q || rsp_o.ready;

  // Intercept wraps to its 11-bit width.
  assign icpt_sum = (IcptW+1)'(HighVMv) - (IcptW+1)'(stage[SlopeW].quo_i)
                  + (IcptW+1)'(stage[SlopeW].offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rdy[SlopeW]) begin
      rsp_vld_q <= vld[SlopeW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld[SlopeW] && rdy[SlopeW]) begin
      rsp_slope_q <= stage[SlopeW].quo_s;
      rsp_icpt_q  <= signed'(icpt_sum[IcptW-1:0]);
    end
  end

  assign rsp_o.valid     = rsp_vld_q;
  assign rsp_o.slope     = rsp_slope_q;
  assign rsp_o.intercept = rsp_icpt_q;

`ifndef ASSERT_OFF
  a_slope_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[SlopeW] |-> (stage[SlopeW].rem_s < RemSW'(stage[SlopeW].span)))
    else $error("slope remainder not below span after last cell");

  a_icpt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[SlopeW] |-> (stage[SlopeW].rem_i < RemIW'(stage[SlopeW].span)))
    else $error("intercept remainder not below span after last cell");

  a_icpt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> ((rsp_icpt_q >= -11'sd125) && (rsp_icpt_q <= 11'sd212)))
    else $error("intercept out of its possible range");
`endif

endmodule

/* test/adctpc_coeff_monitor.sv */
// Coefficient monitor: tracks the fuse word, predicts slope and intercept per request
// and compares each response in order. Depends on adctpc_pkg and the channel interfaces.
`timescale 1ns / 1ps

module adctpc_coeff_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  adctpc_cfg_if       cfg_i,
  adctpc_req_if       req_i,
  adctpc_rsp_if       rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import adctpc_pkg::*;

  localparam int VoltSpanMv    = 700;
  localparam int HighPointMv   = 850;
  localparam int CountsPerStep = 4;
  localparam int MaxReports    = 200;

  localparam logic [6:0] LowCodeSignOnly  = 7'h40;
  localparam logic [8:0] HighCodeSignOnly = 9'h100;

  localparam int LowNomCounts  [2] = '{278, 421};
  localparam int HighNomCounts [2] = '{3265, 3406};

  localparam int ScaleTab [2][4] = '{
    '{65504, 86975, 120389, 224310},
    '{65467, 86861, 120416, 224708}
  };
  localparam int OffsetTab [2][4] = '{
    '{0, 1, 27, 54},
    '{0, 9, 26, 66}
  };

  typedef struct {
    logic                    unit;
    logic [1:0]              att;
    logic [SlopeW-1:0]       slope;
    logic signed [IcptW-1:0] intercept;
  } coeffs_t;

  logic [FuseW-1:0] fuse_q = '0;
  coeffs_t          expected_coeffs [$];
  int unsigned      reports;

  function automatic coeffs_t predict_coeffs(input logic [FuseW-1:0] fuse,
                                             input logic unit, input logic [1:0] att);
    logic [6:0] lo_code;
    logic [8:0] hi_code;
    longint     lo_step, hi_step, lo_raw, hi_raw, span, slope_q, hi_mv, icpt;
    coeffs_t    c;
    lo_code = unit ? fuse[22:16] : fuse[6:0];
    hi_code = unit ? fuse[31:23] : fuse[15:7];
    // sign bit alone reads as zero, not as the most negative step
    lo_step = (lo_code == LowCodeSignOnly) ? 0 : longint'($signed(lo_code));
    hi_step = (hi_code == HighCodeSignOnly) ? 0 : longint'($signed(hi_code));
    lo_raw  = LowNomCounts[unit] + lo_step * CountsPerStep;
    hi_raw  = HighNomCounts[unit] + hi_step * CountsPerStep;
    span    = hi_raw - lo_raw;
    slope_q = (VoltSpanMv * ScaleTab[unit][att] + span / 2) / span;
    hi_mv   = (VoltSpanMv * hi_raw + span / 2) / span;
    icpt    = HighPointMv - hi_mv + OffsetTab[unit][att];
    c.unit      = unit;
    c.att       = att;
    c.slope     = slope_q[SlopeW-1:0];
    c.intercept = icpt[IcptW-1:0];
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coeffs_t want;
    if (!rst_ni) begin
      fuse_q = '0;
      expected_coeffs.delete();
    end else begin
      // retire the response before queueing a request taken at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_coeffs.size() == 0) begin
          fail_count_o++;
          if (reports++ < MaxReports)
            $display("%0t: unexpected item: expected none, actual slope %0d intercept %0d",
                     $time, rsp_i.slope, rsp_i.intercept);
        end else begin
          want = expected_coeffs.pop_front();
          if (rsp_i.slope !== want.slope) begin
            fail_count_o++;
            if (reports++ < MaxReports)
              $display("%0t: slope (unit %0d, att %0d): expected %0d, actual %0d",
                       $time, want.unit, want.att, want.slope, rsp_i.slope);
          end
          if (rsp_i.intercept !== want.intercept) begin
            fail_count_o++;
            if (reports++ < MaxReports)
              $display("%0t: intercept (unit %0d, att %0d): expected %0d, actual %0d",
                       $time, want.unit, want.att, want.intercept, rsp_i.intercept);
          end
        end
      end
      if (req_i.valid && req_i.ready)
        expected_coeffs.push_back(predict_coeffs(fuse_q, req_i.adc_unit, req_i.attenuation));
      if (cfg_i.valid && cfg_i.ready)
        fuse_q = cfg_i.fuse_word;
    end
    pending_o = expected_coeffs.size();
  end

endmodule

/* test/adc_two_point_calibration_coeffs_tb.sv */
// Testbench top: clock, reset, fuse writes, bursty requests and a stalling response side.
// Depends on adctpc_pkg, the channel interfaces, the block and adctpc_coeff_monitor.
`timescale 1ns / 1ps

module adc_two_point_calibration_coeffs_tb;
  import adctpc_pkg::*;

  localparam int unsigned HoldCycles    = 24;
  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned RandPhases    = 14;
  localparam int unsigned ItemsPerPhase = 125;

  // sign-only, most negative, most positive, narrowest and widest span, all ones
  localparam logic [FuseW-1:0] EdgeFuses [6] = '{
    32'h8040_8040, 32'h80C1_80C1, 32'h7FBF_7FBF,
    32'h80BF_80BF, 32'h7FC1_7FC1, 32'hFFFF_FFFF
  };

  typedef enum logic [1:0] {RdyAlways, RdyMostly, RdySparse, RdyBlocked} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned stall_tick;
  stall_mode_e stall_mode = RdyAlways;

  adctpc_cfg_if cfg_ch ();
  adctpc_req_if req_ch ();
  adctpc_rsp_if rsp_ch ();

  adc_two_point_calibration_coeffs uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  adctpc_coeff_monitor coeff_mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_ch),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk = ~clk;

  // End the run when no item moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready) ||
        (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response side: pick a new random stall pattern each time the low eight bits of stall_tick return to zero.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_tick[7:0] == 8'd0) stall_mode = stall_mode_e'($urandom_range(0, 3));
      case (stall_mode)
        RdyAlways:  rsp_ch.ready = 1'b1;
        RdyMostly:  rsp_ch.ready = ($urandom_range(0, 3) != 0);
        RdySparse:  rsp_ch.ready = ($urandom_range(0, 3) == 0);
        default:    rsp_ch.ready = (stall_tick[5:0] >= 6'd40);
      endcase
      stall_tick++;
    end
  end

  // Hold valid across a burst; drop it for a random gap between bursts.
  task automatic send_request(input logic unit, input logic [1:0] att);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid       = 1'b1;
    req_ch.adc_unit    = unit;
    req_ch.attenuation = att;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the fuse word once every outstanding result has drained.
  task automatic write_fuse(input logic [FuseW-1:0] value);
    req_ch.valid = 1'b0;
    burst_left   = 0;
    while (pending != 0) @(negedge clk);
    repeat (HoldCycles) @(negedge clk);
    cfg_ch.valid     = 1'b1;
    cfg_ch.fuse_word = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [6:0] pick_low_code();
    case ($urandom_range(0, 4))
      0:       return 7'h40;
      1:       return 7'h41;
      2:       return 7'h3F;
      3:       return 7'h00;
      default: return 7'($urandom());
    endcase
  endfunction

  function automatic logic [8:0] pick_high_code();
    case ($urandom_range(0, 4))
      0:       return 9'h100;
      1:       return 9'h101;
      2:       return 9'h0FF;
      3:       return 9'h000;
      default: return 9'($urandom());
    endcase
  endfunction

  function automatic logic [FuseW-1:0] pick_fuse();
    logic [FuseW-1:0] f;
    f = $urandom();
    if ($urandom_range(0, 1) == 1) begin
      f[6:0]   = pick_low_code();
      f[15:7]  = pick_high_code();
      f[22:16] = pick_low_code();
      f[31:23] = pick_high_code();
    end
    return f;
  endfunction

  initial begin
    int unsigned k;
    cfg_ch.valid       = 1'b0;
    cfg_ch.fuse_word   = '0;
    req_ch.valid       = 1'b0;
    req_ch.adc_unit    = 1'b0;
    req_ch.attenuation = 2'd0;
    burst_left         = 0;
    rst_n              = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset fuse word: every unit and attenuation level
    for (k = 0; k < 8; k++) send_request(k[2], k[1:0]);
    for (k = 0; k < $size(EdgeFuses); k++) begin
      write_fuse(EdgeFuses[k]);
      send_request(1'b0, 2'(k));
      send_request(1'b1, 2'(k + 1));
    end

    for (k = 0; k < RandPhases; k++) begin
      write_fuse(pick_fuse());
      repeat (ItemsPerPhase)
        send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    end
    req_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (HoldCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
